// File: sv/return_address_translator_core_defines.svh
// assertion macros for the return address translator
// no dependencies; modules that check themselves take it by include

`ifndef RETURN_ADDRESS_TRANSLATOR_CORE_DEFINES_SVH
`define RETURN_ADDRESS_TRANSLATOR_CORE_DEFINES_SVH

`ifndef SYNTH
`define RAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define RAT_ASSERT(lbl, prop, msg)
`define RAT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: sv/rat_pkg.sv
// shared types and constants of the return address translator
// no dependencies; used by every module of the block

package rat_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_CNT_W = 13;
  localparam int unsigned SLOT_W = 12;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned ADDR_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROGRAM_BASE = 1'b0,
    REG_ENTRY_COUNT  = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_XLATE = 1'b1
  } action_e;

  typedef struct packed {
    logic              action;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  shadow_offset;
    logic [KEY_W-1:0]  original_offset;
    logic [ADDR_W-1:0] return_addr;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] translated_addr;
    logic              found;
  } out_word_t;

  typedef struct packed {
    logic vld;
    logic xlate;
    logic wr_ok;
    logic done;
    logic hit;
  } tok_ctl_t;

  typedef struct packed {
    tok_ctl_t          ctl;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  val;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  off;
    logic [KEY_W-1:0]  hit_val;
  } tok_t;

endpackage

// File: sv/rat_ends.sv
// endpoint stage: checks the lowest and highest valid entries of a table copy
// depends on rat_pkg

module rat_ends import rat_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 4096,
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tok_t             tok_i,
  input  logic [IDX_W-1:0] hi_i,
  output tok_t             tok_o,
  output logic [IDX_W-1:0] lo_o,
  output logic [IDX_W-1:0] hi_o
);

  logic [2*KEY_W-1:0] mem_q [TABLE_DEPTH];
  logic [2*KEY_W-1:0] rd_lo_q, rd_hi_q;
  logic [IDX_W-1:0]   wr_idx;
  tok_t               tok_q, tok_d, tok_out_q;
  logic [IDX_W-1:0]   hi_q, hi_out_q;
  logic [KEY_W-1:0]   key_lo, key_hi;

  assign wr_idx = IDX_W'({20'd0, tok_i.slot});

  always_ff @(posedge clk_i) begin
    if (tok_i.ctl.vld && !tok_i.ctl.xlate && tok_i.ctl.wr_ok) begin
      mem_q[wr_idx] <= {tok_i.key, tok_i.val};
    end
    rd_lo_q <= mem_q['0];
    rd_hi_q <= mem_q[hi_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q     <= '0;
      tok_out_q <= '0;
    end else begin
      tok_q     <= tok_i;
      tok_out_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q     <= hi_i;
    hi_out_q <= hi_q;
  end

  assign key_lo = rd_lo_q[2*KEY_W-1:KEY_W];
  assign key_hi = rd_hi_q[2*KEY_W-1:KEY_W];

  always_comb begin
    tok_d = tok_q;
    if (tok_q.ctl.vld && tok_q.ctl.xlate && !tok_q.ctl.done) begin
      if (key_lo > tok_q.off || key_hi < tok_q.off) begin
        tok_d.ctl.done = 1'b1;
      end else if (key_lo == tok_q.off) begin
        tok_d.ctl.done = 1'b1;
        tok_d.ctl.hit  = 1'b1;
        tok_d.hit_val  = rd_lo_q[KEY_W-1:0];
      end else if (key_hi == tok_q.off) begin
        tok_d.ctl.done = 1'b1;
        tok_d.ctl.hit  = 1'b1;
        tok_d.hit_val  = rd_hi_q[KEY_W-1:0];
      end
    end
  end

  assign tok_o = tok_out_q;
  assign lo_o  = '0;
  assign hi_o  = hi_out_q;

endmodule

// File: sv/rat_probe.sv
// one binary search level: probes the middle entry of its own table copy
// depends on rat_pkg and the assertion macro header

`include "return_address_translator_core_defines.svh"

module rat_probe import rat_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 4096,
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tok_t             tok_i,
  input  logic [IDX_W-1:0] lo_i,
  input  logic [IDX_W-1:0] hi_i,
  output tok_t             tok_o,
  output logic [IDX_W-1:0] lo_o,
  output logic [IDX_W-1:0] hi_o
);

  logic [2*KEY_W-1:0] mem_q [TABLE_DEPTH];
  logic [2*KEY_W-1:0] rd_q;
  logic [IDX_W-1:0]   wr_idx, mid;
  logic [IDX_W:0]     sum, span;
  logic               act;
  tok_t               tok_q, tok_d, tok_out_q;
  logic [IDX_W-1:0]   lo_q, hi_q, mid_q, lo_d, hi_d, lo_out_q, hi_out_q;
  logic               act_q;
  logic [KEY_W-1:0]   key;

  assign wr_idx = IDX_W'({20'd0, tok_i.slot});
  assign sum    = {1'b0, lo_i} + {1'b0, hi_i};
  assign span   = {1'b0, hi_i} - {1'b0, lo_i};
  assign mid    = sum[IDX_W:1];
  assign act    = tok_i.ctl.vld && tok_i.ctl.xlate && !tok_i.ctl.done
                  && (span > (IDX_W+1)'(1));

  always_ff @(posedge clk_i) begin
    if (tok_i.ctl.vld && !tok_i.ctl.xlate && tok_i.ctl.wr_ok) begin
      mem_q[wr_idx] <= {tok_i.key, tok_i.val};
    end
    rd_q <= mem_q[mid];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q     <= '0;
      act_q     <= 1'b0;
      tok_out_q <= '0;
    end else begin
      tok_q     <= tok_i;
      act_q     <= act;
      tok_out_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_i;
    hi_q     <= hi_i;
    mid_q    <= mid;
    lo_out_q <= lo_d;
    hi_out_q <= hi_d;
  end

  assign key = rd_q[2*KEY_W-1:KEY_W];

  always_comb begin
    tok_d = tok_q;
    lo_d  = lo_q;
    hi_d  = hi_q;
    if (act_q) begin
      if (key < tok_q.off) begin
        lo_d = mid_q;
      end else if (key > tok_q.off) begin
        hi_d = mid_q;
      end else begin
        tok_d.ctl.done = 1'b1;
        tok_d.ctl.hit  = 1'b1;
        tok_d.hit_val  = rd_q[KEY_W-1:0];
      end
    end
  end

  assign tok_o = tok_out_q;
  assign lo_o  = lo_out_q;
  assign hi_o  = hi_out_q;

  `RAT_ASSERT(a_mid_inside, act_q |-> ((lo_q < mid_q) && (mid_q < hi_q)), "probe outside interval")
  `RAT_ASSERT(a_hit_done, tok_o.ctl.hit |-> (tok_o.ctl.done && tok_o.ctl.xlate), "hit without done")

endmodule

// File: sv/return_address_translator_core.sv
// top level of the return address translator: input stage, search pipeline, result stage
// depends on rat_pkg, rat_ends, rat_probe and the assertion macro header
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------
//   input    | start, busy          | in_word_i  (in_word_t)
//   result   | done_o strobe        | out_word_o (out_word_t)
//   config   | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// a word enters every cycle; its result passes through the input stage, the endpoint stage,
// two stages per search level and the result stage
// the endpoint stage and every search level own a table copy, loads write each copy as they pass, so order is kept
// reset clears the tokens, the config registers and done_o; table contents are undefined until loaded
// busy stays low and results go out on done_o for one cycle each

`include "return_address_translator_core_defines.svh"

module return_address_translator_core import rat_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              in_word_i,
  output logic                  done_o,
  output out_word_t             out_word_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LEVELS = $clog2(TABLE_DEPTH);

  logic [ADDR_W-1:0]    base_q;
  logic [CFG_CNT_W-1:0] count_q;

  logic [ADDR_W-1:0] diff;
  logic [CNT_W-1:0]  n;
  tok_t              tok0_d, tok0_q;
  logic [IDX_W-1:0]  hi0_d, hi0_q;

  tok_t             chain_tok [LEVELS+1];
  logic [IDX_W-1:0] chain_lo  [LEVELS+1];
  logic [IDX_W-1:0] chain_hi  [LEVELS+1];
  tok_t             fin_tok;

  out_word_t out_d, out_q;
  logic      done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PROGRAM_BASE: base_q  <= cfg_wdata_i;
        REG_ENTRY_COUNT:  count_q <= cfg_wdata_i[CFG_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  assign diff = in_word_i.return_addr - base_q;
  assign n    = ({19'd0, count_q} > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(count_q);

  always_comb begin
    tok0_d           = '0;
    tok0_d.ctl.vld   = start && !busy;
    tok0_d.ctl.xlate = (in_word_i.action == ACT_XLATE);
    tok0_d.ctl.wr_ok = ({20'd0, in_word_i.slot} < 32'(TABLE_DEPTH));
    tok0_d.ctl.done  = !tok0_d.ctl.xlate || (n == '0) || (diff[ADDR_W-1:KEY_W] != '0);
    tok0_d.slot      = in_word_i.slot;
    tok0_d.key       = in_word_i.shadow_offset;
    tok0_d.val       = in_word_i.original_offset;
    tok0_d.addr      = in_word_i.return_addr;
    tok0_d.off       = diff[KEY_W-1:0];
    hi0_d            = tok0_d.ctl.done ? '0 : IDX_W'(n - CNT_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok0_q <= '0;
    end else begin
      tok0_q <= tok0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi0_q <= hi0_d;
  end

  rat_ends #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ends (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tok_i (tok0_q),
    .hi_i  (hi0_q),
    .tok_o (chain_tok[0]),
    .lo_o  (chain_lo[0]),
    .hi_o  (chain_hi[0])
  );

  for (genvar g = 0; g < LEVELS; g++) begin : g_level
    rat_probe #(
      .TABLE_DEPTH(TABLE_DEPTH)
    ) u_probe (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (chain_tok[g]),
      .lo_i  (chain_lo[g]),
      .hi_i  (chain_hi[g]),
      .tok_o (chain_tok[g+1]),
      .lo_o  (chain_lo[g+1]),
      .hi_o  (chain_hi[g+1])
    );
  end

  assign fin_tok = chain_tok[LEVELS];

  always_comb begin
    out_d = '0;
    if (fin_tok.ctl.xlate) begin
      out_d.found = fin_tok.ctl.hit;
      out_d.translated_addr = fin_tok.ctl.hit ? ({32'd0, fin_tok.hit_val} + base_q)
                                              : fin_tok.addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fin_tok.ctl.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o     = done_q;
  assign out_word_o = out_q;

  `RAT_ASSERT(a_strobe_src, done_o |-> $past(fin_tok.ctl.vld), "result without word")
  `RAT_ASSERT(a_load_zero, (done_o && !$past(fin_tok.ctl.xlate)) |-> (out_word_o == '0), "load nonzero")

endmodule
